FILE: src/leaky_integrate_fire_neuron_assert.svh
// assertion macros for the leaky integrate-and-fire neuron block
// no dependencies; included by the top level
`ifndef LEAKY_INTEGRATE_FIRE_NEURON_ASSERT_SVH
`define LEAKY_INTEGRATE_FIRE_NEURON_ASSERT_SVH

// same-cycle implication under synchronous reset
`define LIF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under synchronous reset
`define LIF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lif_pkg.sv
// shared types and constants for the leaky integrate-and-fire neuron block
// no dependencies
`default_nettype none

package lif_pkg;

  localparam int INDEX_BITS     = 10;
  localparam int CURRENT_BITS   = 24;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 24;
  localparam int DECAY_BITS     = 13;
  localparam int DECAY_SHIFT    = 12;
  localparam int REFRACT_BITS   = 8;
  localparam int S_TDATA_BITS   = 40;
  localparam int M_TDATA_BITS   = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FIRE_THRESHOLD          = 8'd0,
    REG_REVERSE_LIMIT           = 8'd1,
    REG_RESET_POTENTIAL         = 8'd2,
    REG_REVERSE_RESET_POTENTIAL = 8'd3,
    REG_MODE_BITS               = 8'd4,
    REG_POTENTIAL_DECAY         = 8'd5,
    REG_CURRENT_DECAY           = 8'd6,
    REG_BIAS_CURRENT            = 8'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_SOFT = 2'd1,
    MODE_HARD = 2'd2,
    MODE_SAT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_IDLE    = 2'd0,
    STATUS_UPDATED = 2'd1,
    STATUS_FIRED   = 2'd2
  } status_t;

  localparam logic [23:0] RST_FIRE_THRESHOLD          = 24'd64;
  localparam logic [23:0] RST_REVERSE_LIMIT           = 24'h800000;
  localparam logic [23:0] RST_RESET_POTENTIAL         = 24'd0;
  localparam logic [23:0] RST_REVERSE_RESET_POTENTIAL = 24'd0;
  localparam logic [4:0]  RST_MODE_BITS               = 5'd0;
  localparam logic [12:0] RST_POTENTIAL_DECAY         = 13'd4096;
  localparam logic [12:0] RST_CURRENT_DECAY           = 13'd0;
  localparam logic [23:0] RST_BIAS_CURRENT            = 24'd0;

  typedef struct packed {
    logic [23:0]           fire_threshold;
    logic [23:0]           reverse_limit;
    logic [23:0]           reset_potential;
    logic [23:0]           reverse_reset_potential;
    logic [4:0]            mode_bits;
    logic [DECAY_BITS-1:0] potential_decay;
    logic [DECAY_BITS-1:0] current_decay;
    logic [23:0]           bias_current;
  } cfg_t;

  typedef struct packed {
    logic adv;
    logic accept;
  } pipe_ctrl_t;

  typedef struct packed {
    logic clearing;
    logic hazard;
  } pipe_stat_t;

  typedef struct packed {
    logic                  valid;
    logic [INDEX_BITS-1:0] index;
    status_t               status;
  } result_t;

endpackage

`default_nettype wire

FILE: src/lif_cfg.sv
// shared configuration registers of the neuron block
// depends on lif_pkg
`default_nettype none

module lif_cfg import lif_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_valid,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [CFG_DATA_BITS-1:0]  wr_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fire_threshold          <= RST_FIRE_THRESHOLD;
      cfg.reverse_limit           <= RST_REVERSE_LIMIT;
      cfg.reset_potential         <= RST_RESET_POTENTIAL;
      cfg.reverse_reset_potential <= RST_REVERSE_RESET_POTENTIAL;
      cfg.mode_bits               <= RST_MODE_BITS;
      cfg.potential_decay         <= RST_POTENTIAL_DECAY;
      cfg.current_decay           <= RST_CURRENT_DECAY;
      cfg.bias_current            <= RST_BIAS_CURRENT;
    end else if (wr_valid) begin
      unique case (wr_index)
        REG_FIRE_THRESHOLD:          cfg.fire_threshold          <= wr_data;
        REG_REVERSE_LIMIT:           cfg.reverse_limit           <= wr_data;
        REG_RESET_POTENTIAL:         cfg.reset_potential         <= wr_data;
        REG_REVERSE_RESET_POTENTIAL: cfg.reverse_reset_potential <= wr_data;
        REG_MODE_BITS:               cfg.mode_bits               <= wr_data[4:0];
        REG_POTENTIAL_DECAY:         cfg.potential_decay         <= wr_data[DECAY_BITS-1:0];
        REG_CURRENT_DECAY:           cfg.current_decay           <= wr_data[DECAY_BITS-1:0];
        REG_BIAS_CURRENT:            cfg.bias_current            <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/lif_update.sv
// state memory and five-stage read-modify-write update pipeline
// depends on lif_pkg
`default_nettype none

module lif_update import lif_pkg::*; #(
  parameter int NEURONS        = 1024,
  parameter int REFRACT_CYCLES = 0,
  parameter int VALUE_BITS     = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pipe_ctrl_t              ctrl,
  input  cfg_t                    cfg,
  input  logic [INDEX_BITS-1:0]   in_index,
  input  logic                    in_has,
  input  logic [CURRENT_BITS-1:0] in_current,
  output pipe_stat_t              stat,
  output result_t                 result
);

  localparam int VB       = VALUE_BITS;
  localparam int AW       = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int MW       = 2 * VB + REFRACT_BITS;
  localparam int PW       = VB + DECAY_BITS + 1;
  localparam int XW       = 17;
  localparam int CW       = 33;
  localparam logic [XW-1:0] NEURON_COUNT = XW'(NEURONS);
  localparam logic [AW-1:0] LAST_ADDR    = AW'(NEURONS - 1);
  localparam logic [PW-1:0] ROUND_ADJ    = PW'((1 << DECAY_SHIFT) - 1);
  localparam logic [REFRACT_BITS-1:0] RELOAD = REFRACT_BITS'(REFRACT_CYCLES);

  // state memory: {refractory, filtered current, potential}
  logic [MW-1:0] mem [NEURONS];
  logic [MW-1:0] rd_word;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_word;

  logic          clearing;
  logic [AW-1:0] clr_addr;

  // sign-extended config values and input current
  logic [31:0] thr_x, lim_x, rp_x, rrp_x, bias_x, cur_x;
  logic [VB-1:0] thr_v, lim_v, rp_v, rrp_v, bias_v, cur_v;
  logic [CW-1:0] thr_c, lim_c;

  logic [XW-1:0] in_index_x, e_index_x;
  logic [AW-1:0] rd_addr;

  // stage a
  logic                    a_valid, a_ok, a_has;
  logic [INDEX_BITS-1:0]   a_index;
  logic [VB-1:0]           a_cur;
  logic [VB-1:0]           v_r, ic_r;
  logic [REFRACT_BITS-1:0] rc_r;
  logic                    upd_a;
  logic signed [PW-1:0]    pv_next, pic_next;

  // stage b
  logic                    b_valid, b_ok, b_has, b_upd, b_rc0;
  logic [INDEX_BITS-1:0]   b_index;
  logic [VB-1:0]           b_cur;
  logic [REFRACT_BITS-1:0] b_rc;
  logic signed [PW-1:0]    b_pv, b_pic;
  logic [PW-1:0]           pv_adj, pic_adj;
  logic [VB-1:0]           vd, icd;

  // stage c
  logic                    c_valid, c_ok, c_upd, c_rc0;
  logic [INDEX_BITS-1:0]   c_index;
  logic [REFRACT_BITS-1:0] c_rc;
  logic [VB-1:0]           c_vb, c_icn;
  logic [VB-1:0]           vs;
  logic [CW-1:0]           vs_c;
  logic                    fire;

  // stage d
  logic                    d_valid, d_ok, d_upd, d_rc0, d_fire;
  logic [INDEX_BITS-1:0]   d_index;
  logic [REFRACT_BITS-1:0] d_rc;
  logic [VB-1:0]           d_vs, d_icn;
  logic [VB-1:0]           vf;
  logic [REFRACT_BITS-1:0] rc_load, rc_dec;
  status_t                 status_d;

  // stage e
  logic                    e_valid, e_ok, e_rc0;
  logic [INDEX_BITS-1:0]   e_index;
  logic [REFRACT_BITS-1:0] e_rc;
  logic [VB-1:0]           e_vf, e_icn;
  status_t                 e_status;
  logic [CW-1:0]           vf_c;
  logic                    rev;
  logic [VB-1:0]           vr;

  assign thr_x  = {{8{cfg.fire_threshold[23]}}, cfg.fire_threshold};
  assign lim_x  = {{8{cfg.reverse_limit[23]}}, cfg.reverse_limit};
  assign rp_x   = {{8{cfg.reset_potential[23]}}, cfg.reset_potential};
  assign rrp_x  = {{8{cfg.reverse_reset_potential[23]}}, cfg.reverse_reset_potential};
  assign bias_x = {{8{cfg.bias_current[23]}}, cfg.bias_current};
  assign cur_x  = {{8{in_current[23]}}, in_current};
  assign thr_v  = thr_x[VB-1:0];
  assign lim_v  = lim_x[VB-1:0];
  assign rp_v   = rp_x[VB-1:0];
  assign rrp_v  = rrp_x[VB-1:0];
  assign bias_v = bias_x[VB-1:0];
  assign cur_v  = cur_x[VB-1:0];
  assign thr_c  = {{(CW-24){cfg.fire_threshold[23]}}, cfg.fire_threshold};
  assign lim_c  = {{(CW-24){cfg.reverse_limit[23]}}, cfg.reverse_limit};

  assign in_index_x = {{(XW-INDEX_BITS){1'b0}}, in_index};
  assign e_index_x  = {{(XW-INDEX_BITS){1'b0}}, e_index};
  assign rd_addr    = in_index_x[AW-1:0];

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  assign wr_en   = clearing || (ctrl.adv && e_valid && e_ok);
  assign wr_addr = clearing ? clr_addr : e_index_x[AW-1:0];
  assign wr_word = clearing ? '0 : {e_rc, e_icn, vr};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (ctrl.adv) begin
      rd_word <= mem[rd_addr];
    end
  end

  // interlock against any in-flight update of the same compartment
  assign stat.hazard = (a_valid && a_index == in_index) || (b_valid && b_index == in_index) ||
                       (c_valid && c_index == in_index) || (d_valid && d_index == in_index) ||
                       (e_valid && e_index == in_index);
  assign stat.clearing = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else if (ctrl.adv) begin
      a_valid <= ctrl.accept;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
    end
  end

  // stage a: read data, status flag, decay products
  assign v_r   = rd_word[VB-1:0];
  assign ic_r  = rd_word[2*VB-1:VB];
  assign rc_r  = rd_word[MW-1:2*VB];
  assign upd_a = (v_r != '0) || a_has || (cfg.bias_current != '0) || cfg.mode_bits[4];
  assign pv_next  = $signed({{(DECAY_BITS+1){v_r[VB-1]}}, v_r}) *
                    $signed({{(PW-DECAY_BITS){1'b0}}, cfg.potential_decay});
  assign pic_next = $signed({{(DECAY_BITS+1){ic_r[VB-1]}}, ic_r}) *
                    $signed({{(PW-DECAY_BITS){1'b0}}, cfg.current_decay});

  // stage b: divide by 4096 toward zero, add bias and input
  assign pv_adj  = b_pv + (b_pv[PW-1] ? ROUND_ADJ : '0);
  assign pic_adj = b_pic + (b_pic[PW-1] ? ROUND_ADJ : '0);
  assign vd      = pv_adj[VB+DECAY_SHIFT-1:DECAY_SHIFT];
  assign icd     = pic_adj[VB+DECAY_SHIFT-1:DECAY_SHIFT];

  // stage c: integrate and compare with the forward threshold
  assign vs   = c_rc0 ? c_vb + c_icn : c_vb;
  assign vs_c = {{(CW-VB){vs[VB-1]}}, vs};
  assign fire = c_rc0 && ($signed(vs_c) > $signed(thr_c));

  // stage d: forward reset and refractory count
  always_comb begin
    vf = d_vs;
    if (d_fire) begin
      case (mode_t'(cfg.mode_bits[1:0]))
        MODE_SOFT: vf = d_vs - thr_v;
        MODE_HARD: vf = rp_v;
        default:   vf = d_vs;
      endcase
    end
  end

  assign rc_load = d_fire ? RELOAD : d_rc;
  assign rc_dec  = (rc_load != '0) ? rc_load - REFRACT_BITS'(1) : '0;

  always_comb begin
    if (!d_ok) begin
      status_d = STATUS_IDLE;
    end else if (d_fire) begin
      status_d = STATUS_FIRED;
    end else if (d_upd) begin
      status_d = STATUS_UPDATED;
    end else begin
      status_d = STATUS_IDLE;
    end
  end

  // stage e: reverse threshold and write back
  assign vf_c = {{(CW-VB){e_vf[VB-1]}}, e_vf};
  assign rev  = e_rc0 && ($signed(vf_c) < $signed(lim_c));

  always_comb begin
    vr = e_vf;
    if (rev) begin
      case (mode_t'(cfg.mode_bits[3:2]))
        MODE_SOFT: vr = e_vf - lim_v;
        MODE_HARD: vr = rrp_v;
        MODE_SAT:  vr = lim_v;
        default:   vr = e_vf;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      a_index <= in_index;
      a_ok    <= in_index_x < NEURON_COUNT;
      a_has   <= in_has;
      a_cur   <= cur_v;

      b_index <= a_index;
      b_ok    <= a_ok;
      b_has   <= a_has;
      b_cur   <= a_cur;
      b_upd   <= upd_a;
      b_rc    <= rc_r;
      b_rc0   <= (rc_r == '0);
      b_pv    <= pv_next;
      b_pic   <= pic_next;

      c_index <= b_index;
      c_ok    <= b_ok;
      c_upd   <= b_upd;
      c_rc    <= b_rc;
      c_rc0   <= b_rc0;
      c_vb    <= b_rc0 ? vd + bias_v : vd;
      c_icn   <= (b_rc0 && b_has) ? icd + b_cur : icd;

      d_index <= c_index;
      d_ok    <= c_ok;
      d_upd   <= c_upd;
      d_rc    <= c_rc;
      d_rc0   <= c_rc0;
      d_vs    <= vs;
      d_icn   <= c_icn;
      d_fire  <= fire;

      e_index  <= d_index;
      e_ok     <= d_ok;
      e_rc0    <= d_rc0;
      e_rc     <= rc_dec;
      e_vf     <= vf;
      e_icn    <= d_icn;
      e_status <= status_d;
    end
  end

  assign result.valid  = e_valid;
  assign result.index  = e_index;
  assign result.status = e_status;

endmodule

`default_nettype wire

FILE: src/leaky_integrate_fire_neuron.sv
// top level of the leaky integrate-and-fire neuron block; uses lif_pkg, lif_cfg, lif_update
// path: an accepted transaction passes the five pipeline stages a to e, then the output register
// throughput: one transaction per cycle for distinct compartments while the skid is free;
//   an update of a compartment still in the five-stage read-modify-write pipeline waits
// reset: synchronous; after rst a clearing pass zeroes every address of the state memory,
//   s_tready stays low meanwhile, config writes are taken at once
`default_nettype none
`include "leaky_integrate_fire_neuron_assert.svh"

module leaky_integrate_fire_neuron import lif_pkg::*; #(
  parameter int NEURONS        = 1024,
  parameter int REFRACT_CYCLES = 0,
  parameter int VALUE_BITS     = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [S_TDATA_BITS-1:0]   s_tdata,    // neuron_index[9:0], current_value[33:10]
  input  logic [0:0]                s_tuser,    // has_current[0]
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [M_TDATA_BITS-1:0]   m_tdata,    // neuron_out[9:0]
  output logic [1:0]                m_tuser,    // status[1:0]
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t       cfg;
  pipe_ctrl_t ctrl;
  pipe_stat_t stat;
  result_t    result;

  logic                  o0_valid, o1_valid;
  logic [INDEX_BITS-1:0] o0_index, o1_index;
  status_t               o0_status, o1_status;
  logic                  push, pop;

  assign cfg_ready = 1'b1;

  lif_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // pipeline moves while the skid entry is free
  assign ctrl.adv    = !o1_valid;
  assign s_tready    = !o1_valid && !stat.clearing && !stat.hazard;
  assign ctrl.accept = s_tvalid && s_tready;

  lif_update #(
    .NEURONS        (NEURONS),
    .REFRACT_CYCLES (REFRACT_CYCLES),
    .VALUE_BITS     (VALUE_BITS)
  ) u_update (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .cfg        (cfg),
    .in_index   (s_tdata[INDEX_BITS-1:0]),
    .in_has     (s_tuser[0]),
    .in_current (s_tdata[INDEX_BITS+CURRENT_BITS-1:INDEX_BITS]),
    .stat       (stat),
    .result     (result)
  );

  // output register with skid entry
  assign push = ctrl.adv && result.valid;
  assign pop  = o0_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o0_valid <= 1'b0;
      o1_valid <= 1'b0;
    end else if (pop) begin
      if (o1_valid) begin
        o1_valid <= 1'b0;
      end else begin
        o0_valid <= push;
      end
    end else if (push) begin
      if (o0_valid) begin
        o1_valid <= 1'b1;
      end else begin
        o0_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (o1_valid) begin
        o0_index  <= o1_index;
        o0_status <= o1_status;
      end else if (push) begin
        o0_index  <= result.index;
        o0_status <= result.status;
      end
    end else if (push) begin
      if (o0_valid) begin
        o1_index  <= result.index;
        o1_status <= result.status;
      end else begin
        o0_index  <= result.index;
        o0_status <= result.status;
      end
    end
  end

  assign m_tvalid = o0_valid;
  assign m_tdata  = {{(M_TDATA_BITS-INDEX_BITS){1'b0}}, o0_index};
  assign m_tuser  = o0_status;

  `LIF_ASSERT_IMPLIES(a_skid_order, clk, rst, o1_valid, o0_valid, "skid entry without head entry")
  `LIF_ASSERT_IMPLIES(a_clear_quiet, clk, rst, stat.clearing, !m_tvalid && !s_tready, "activity during clearing pass")
  `LIF_ASSERT_IMPLIES(a_ready_room, clk, rst, s_tready, !o1_valid && !stat.hazard, "accepting with full skid or hazard")

endmodule

`default_nettype wire
